@@ hw/rtl/rfla_pkg.sv @@
// ----------------------------------------------------------------------------
// Register free list allocator package
// Shared constants, item types and codes for the allocator block.
// ----------------------------------------------------------------------------
package rfla_pkg;

    localparam int NUM_REGS    = 18;
    localparam int IDX_W       = $clog2(NUM_REGS);
    localparam int CNT_W       = $clog2(NUM_REGS + 1);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_MARK     = 2'd2,
        OP_FREE_ALL = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ALREADY_FREE = 3'd1,
        ST_RETVAL       = 3'd2,
        ST_INVALID      = 3'd3,
        ST_REFILLED     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CLS_MANAGED = 2'd0,
        CLS_RETVAL  = 2'd1,
        CLS_INVALID = 2'd2
    } t_cls;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] reg_id;
    } t_in;

    typedef struct packed {
        logic [4:0] granted_reg;
        logic [2:0] status;
        logic [4:0] free_count;
    } t_out;

    typedef struct packed {
        t_opcode          op;
        t_cls             cls;
        logic [IDX_W-1:0] reg_idx;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

@@ hw/rtl/rfla_front.sv @@
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts items and classifies the register number of each one.
// ----------------------------------------------------------------------------
module rfla_front (
    input  logic                i_start,
    input  logic                i_busy,
    input  rfla_pkg::t_in       i_item,
    output logic                o_push,
    output rfla_pkg::t_cmd      o_cmd
);

    always_comb begin
        o_push     = i_start && !i_busy;
        o_cmd.op   = rfla_pkg::t_opcode'(i_item.opcode);
        o_cmd.reg_idx = rfla_pkg::IDX_W'(i_item.reg_id);
        if ({1'b0, i_item.reg_id} < 6'(rfla_pkg::NUM_REGS)) begin
            o_cmd.cls = rfla_pkg::CLS_MANAGED;
        end else if ({1'b0, i_item.reg_id} == 6'(rfla_pkg::NUM_REGS)) begin
            o_cmd.cls = rfla_pkg::CLS_RETVAL;
        end else begin
            o_cmd.cls = rfla_pkg::CLS_INVALID;
        end
    end

endmodule

@@ hw/rtl/rfla_queue.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rfla_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rfla_pkg::t_cmd      i_data,
    input  logic                i_pop,
    output rfla_pkg::t_cmd      o_data,
    output rfla_pkg::t_qstat    o_stat
);

    localparam int PTR_W = (rfla_pkg::QUEUE_DEPTH > 1) ? $clog2(rfla_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(rfla_pkg::QUEUE_DEPTH + 1);

    rfla_pkg::t_cmd     r_mem [rfla_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic               do_push;
    logic               do_pop;

    always_comb begin
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == QCNT_W'(rfla_pkg::QUEUE_DEPTH));
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_data       = r_mem[r_rd_ptr];
        n_wr_ptr     = (r_wr_ptr == PTR_W'(rfla_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr     = (r_rd_ptr == PTR_W'(rfla_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/rfla_back.sv @@
// ----------------------------------------------------------------------------
// Allocator back end
// Holds the free list as a shifting row of entries and carries out commands
// in a lookup step followed by an execute step.
// ----------------------------------------------------------------------------
module rfla_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfla_pkg::t_cmd      i_cmd,
    input  rfla_pkg::t_qstat    i_qstat,
    output logic                o_pop,
    output logic                o_done,
    output rfla_pkg::t_out      o_result
);

    localparam int N     = rfla_pkg::NUM_REGS;
    localparam int IDX_W = rfla_pkg::IDX_W;
    localparam int CNT_W = rfla_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_LOOK = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_order [N];
    logic [IDX_W-1:0]   n_order [N];
    logic [CNT_W-1:0]   r_len;
    logic [CNT_W-1:0]   n_len;
    logic [N-1:0]       r_mark;
    logic [N-1:0]       n_mark;
    rfla_pkg::t_cmd     r_cmd;
    logic [IDX_W-1:0]   r_pos;
    logic [IDX_W-1:0]   n_pos;
    logic [IDX_W-1:0]   r_tail;
    logic [IDX_W-1:0]   n_tail;
    logic [IDX_W-1:0]   granted;
    rfla_pkg::t_status  status;
    logic               exec;

    always_comb begin
        o_pop  = (r_state == S_LOOK) && !i_qstat.empty;
        exec   = (r_state == S_EXEC);
        n_pos  = '0;
        for (int j = 0; j < N; j++) begin
            if ((r_order[j] == i_cmd.reg_idx) && (CNT_W'(j) < r_len)) begin
                n_pos = n_pos | IDX_W'(j);
            end
        end
        n_tail = (r_len != '0) ? r_order[IDX_W'(r_len - CNT_W'(1))] : '0;
        n_state = r_state;
        case (r_state)
            S_LOOK: begin
                if (o_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_LOOK;
            end
            default: begin
                n_state = S_LOOK;
            end
        endcase
    end

    always_comb begin
        n_order = r_order;
        n_len   = r_len;
        n_mark  = r_mark;
        granted = '0;
        status  = rfla_pkg::ST_OK;
        if (exec) begin
            case (r_cmd.op)
                rfla_pkg::OP_ALLOC: begin
                    if (r_len == '0) begin
                        for (int j = 0; j < N; j++) begin
                            n_order[j] = IDX_W'(j);
                        end
                        granted = IDX_W'(N - 1);
                        n_len   = CNT_W'(N - 1);
                        n_mark  = '1;
                        n_mark[N-1] = 1'b0;
                        status  = rfla_pkg::ST_REFILLED;
                    end else begin
                        granted         = r_tail;
                        n_len           = r_len - CNT_W'(1);
                        n_mark[r_tail]  = 1'b0;
                    end
                end
                rfla_pkg::OP_FREE: begin
                    case (r_cmd.cls)
                        rfla_pkg::CLS_MANAGED: begin
                            if (r_mark[r_cmd.reg_idx]) begin
                                status = rfla_pkg::ST_ALREADY_FREE;
                            end else if (r_len < CNT_W'(N)) begin
                                for (int j = 1; j < N; j++) begin
                                    n_order[j] = r_order[j-1];
                                end
                                n_order[0] = r_cmd.reg_idx;
                                n_len      = r_len + CNT_W'(1);
                                n_mark[r_cmd.reg_idx] = 1'b1;
                            end
                        end
                        rfla_pkg::CLS_RETVAL: begin
                            status = rfla_pkg::ST_RETVAL;
                        end
                        default: begin
                            status = rfla_pkg::ST_INVALID;
                        end
                    endcase
                end
                rfla_pkg::OP_MARK: begin
                    if (r_cmd.cls == rfla_pkg::CLS_MANAGED) begin
                        if (r_mark[r_cmd.reg_idx]) begin
                            for (int j = 0; j < N - 1; j++) begin
                                if (IDX_W'(j) >= r_pos) begin
                                    n_order[j] = r_order[j+1];
                                end
                            end
                            n_len = r_len - CNT_W'(1);
                            n_mark[r_cmd.reg_idx] = 1'b0;
                        end
                    end else begin
                        status = rfla_pkg::ST_INVALID;
                    end
                end
                default: begin
                    for (int j = 0; j < N; j++) begin
                        n_order[j] = IDX_W'(j);
                    end
                    n_len  = CNT_W'(N);
                    n_mark = '1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOOK;
            r_len   <= CNT_W'(N);
            r_mark  <= '1;
            o_done  <= 1'b0;
            for (int j = 0; j < N; j++) begin
                r_order[j] <= IDX_W'(j);
            end
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_mark  <= n_mark;
            r_order <= n_order;
            o_done  <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_pos  <= n_pos;
            r_tail <= n_tail;
        end
        if (exec) begin
            o_result.granted_reg <= 5'(granted);
            o_result.status      <= 3'(status);
            o_result.free_count  <= 5'(n_len);
        end
    end

endmodule

@@ hw/rtl/register_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// Register free list allocator
// Keeps an ordered free list of register numbers and serves allocate, free,
// mark-used and free-all commands, one result item per input item.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// command   in         i_start high, o_busy low  i_item   (opcode, reg_id)
// result    out        o_done for one cycle    o_result (granted_reg, status,
//                                                        free_count)
//
// Each item takes two steps in the back end: one looks up the register's place
// in the list, one shifts the list and forms the result. An item taken is
// written to the queue, popped into the lookup step and executed; the result
// strobe is registered from the execute step. Up to two items wait in the
// queue; o_busy is high while it is full. Reset restores the list's full order.
// ----------------------------------------------------------------------------
module register_free_list_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rfla_pkg::t_in       i_item,
    output logic                o_busy,
    output logic                o_done,
    output rfla_pkg::t_out      o_result
);

    logic               push;
    logic               pop;
    rfla_pkg::t_cmd     front_cmd;
    rfla_pkg::t_cmd     queue_cmd;
    rfla_pkg::t_qstat   qstat;

    assign o_busy = qstat.full;

    rfla_front u_front (
        .i_start (i_start),
        .i_busy  (o_busy),
        .i_item  (i_item),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    rfla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (queue_cmd),
        .o_stat  (qstat)
    );

    rfla_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (queue_cmd),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

@@ hw/rtl/rfla_checker.sv @@
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the allocator's ports for results that break its rules.
// ----------------------------------------------------------------------------
module rfla_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_done,
    input  rfla_pkg::t_out      i_result
);

    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_done)
        else $error("Result strobe right after reset.");

    a_done_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |=> !i_done)
        else $error("Results in two consecutive cycles.");

    a_refill_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && i_result.status == 3'(rfla_pkg::ST_REFILLED)) |->
        (i_result.granted_reg == 5'(rfla_pkg::NUM_REGS - 1) &&
         i_result.free_count == 5'(rfla_pkg::NUM_REGS - 1)))
        else $error("Refill result does not hand out the last register.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> (i_result.free_count <= 5'(rfla_pkg::NUM_REGS) &&
                    i_result.granted_reg < 5'(rfla_pkg::NUM_REGS)))
        else $error("Result count or register out of range.");

    a_nonalloc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && (i_result.status == 3'(rfla_pkg::ST_ALREADY_FREE) ||
                    i_result.status == 3'(rfla_pkg::ST_RETVAL) ||
                    i_result.status == 3'(rfla_pkg::ST_INVALID))) |->
        i_result.granted_reg == 5'd0)
        else $error("Register handed out by a command other than allocate.");

endmodule

bind register_free_list_allocator rfla_checker u_rfla_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_done   (o_done),
    .i_result (o_result)
);

@@ test/rfla_checker.sv @@
// ----------------------------------------------------------------------------
// Register free list allocator checker
// Watches the command and result channels of the allocator. Every command
// item taken by the block is run through a local copy of the free list to
// form the expected result item, which is queued and compared field by field
// with the next result item that the block reports.
// ----------------------------------------------------------------------------
module rfla_scoreboard (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rfla_pkg::t_in  i_item,
    input  logic           i_busy,
    input  logic           i_done,
    input  rfla_pkg::t_out i_result,
    output int             o_errors,
    output int             o_pending
);

    logic [4:0]                    free_list [rfla_pkg::NUM_REGS];
    int                            free_total;
    logic [rfla_pkg::NUM_REGS-1:0] free_bits;
    rfla_pkg::t_out                result_queue [$];
    rfla_pkg::t_out                oldest_result;
    int                            error_total = 0;
    int                            queue_level = 0;

    assign o_errors  = error_total;
    assign o_pending = queue_level;

    function automatic void restore_free_list();
        for (int i = 0; i < rfla_pkg::NUM_REGS; i++) begin
            free_list[i] = 5'(i);
        end
        free_total = rfla_pkg::NUM_REGS;
        free_bits  = '1;
    endfunction

    function automatic rfla_pkg::t_out apply_command(rfla_pkg::t_in cmd);
        rfla_pkg::t_out res;
        int             slot;
        res = '0;
        case (rfla_pkg::t_opcode'(cmd.opcode))
            rfla_pkg::OP_ALLOC: begin
                if (free_total == 0) begin
                    restore_free_list();
                    res.status = rfla_pkg::ST_REFILLED;
                end
                res.granted_reg = free_list[free_total - 1];
                free_total--;
                free_bits[res.granted_reg] = 1'b0;
            end
            rfla_pkg::OP_FREE: begin
                if (cmd.reg_id < rfla_pkg::NUM_REGS) begin
                    if (free_bits[cmd.reg_id]) begin
                        res.status = rfla_pkg::ST_ALREADY_FREE;
                    end else if (free_total < rfla_pkg::NUM_REGS) begin
                        for (int i = free_total; i > 0; i--) begin
                            free_list[i] = free_list[i - 1];
                        end
                        free_list[0] = cmd.reg_id;
                        free_total++;
                        free_bits[cmd.reg_id] = 1'b1;
                    end
                end else if (cmd.reg_id == rfla_pkg::NUM_REGS) begin
                    res.status = rfla_pkg::ST_RETVAL;
                end else begin
                    res.status = rfla_pkg::ST_INVALID;
                end
            end
            rfla_pkg::OP_MARK: begin
                if (cmd.reg_id < rfla_pkg::NUM_REGS) begin
                    if (free_bits[cmd.reg_id]) begin
                        slot = 0;
                        while (slot < free_total && free_list[slot] != cmd.reg_id) begin
                            slot++;
                        end
                        for (int i = slot; i < free_total - 1; i++) begin
                            free_list[i] = free_list[i + 1];
                        end
                        free_total--;
                        free_bits[cmd.reg_id] = 1'b0;
                    end
                end else begin
                    res.status = rfla_pkg::ST_INVALID;
                end
            end
            default: begin
                restore_free_list();
            end
        endcase
        res.free_count = 5'(free_total);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_free_list();
            result_queue.delete();
        end else begin
            if (i_done) begin
                if (result_queue.size() == 0) begin
                    $error("Result item with no item outstanding: %p", i_result);
                    error_total++;
                end else begin
                    oldest_result = result_queue.pop_front();
                    if (i_result.granted_reg !== oldest_result.granted_reg) begin
                        $error("granted_reg: expected %0d, actual %0d",
                               oldest_result.granted_reg, i_result.granted_reg);
                        error_total++;
                    end
                    if (i_result.status !== oldest_result.status) begin
                        $error("status: expected %0d, actual %0d",
                               oldest_result.status, i_result.status);
                        error_total++;
                    end
                    if (i_result.free_count !== oldest_result.free_count) begin
                        $error("free_count: expected %0d, actual %0d",
                               oldest_result.free_count, i_result.free_count);
                        error_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                result_queue = {result_queue, apply_command(i_item)};
            end
        end
        queue_level = result_queue.size();
    end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Register free list allocator testbench
// Drives a directed run over the special cases of the free list, then a long
// random mix of allocate, free, mark-used and free-all commands with random
// gaps, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1700;
    localparam int MAX_CYCLES   = 400000;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    rfla_pkg::t_in  i_item  = '0;
    logic           o_busy;
    logic           o_done;
    rfla_pkg::t_out o_result;
    int             error_count;
    int             pending_count;
    int             cycle_count = 0;

    always #CLK_HALF i_clk = ~i_clk;

    register_free_list_allocator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    rfla_scoreboard u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_item    (i_item),
        .i_busy    (o_busy),
        .i_done    (o_done),
        .i_result  (o_result),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input rfla_pkg::t_opcode op, input logic [4:0] rid,
                             input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= {op, rid};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    function automatic int pick_gap(bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [4:0] pick_reg();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return 5'($urandom_range(0, rfla_pkg::NUM_REGS - 1));
        end else if (roll < 90) begin
            return 5'(rfla_pkg::NUM_REGS);
        end
        return 5'($urandom_range(rfla_pkg::NUM_REGS + 1, 31));
    endfunction

    initial begin
        rfla_pkg::t_opcode op;
        logic [4:0] rid;
        int roll;
        bit steady;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(rfla_pkg::OP_FREE, 5'd0, 1);
        send_item(rfla_pkg::OP_FREE, 5'(rfla_pkg::NUM_REGS), 0);
        send_item(rfla_pkg::OP_FREE, 5'd31, 0);
        send_item(rfla_pkg::OP_FREE, 5'(rfla_pkg::NUM_REGS + 1), 1);
        send_item(rfla_pkg::OP_MARK, 5'(rfla_pkg::NUM_REGS), 0);
        send_item(rfla_pkg::OP_MARK, 5'd31, 0);
        send_item(rfla_pkg::OP_MARK, 5'd5, 0);
        send_item(rfla_pkg::OP_MARK, 5'd5, 2);
        send_item(rfla_pkg::OP_MARK, 5'd0, 0);
        send_item(rfla_pkg::OP_FREE, 5'd5, 0);
        send_item(rfla_pkg::OP_ALLOC, 5'd31, 0);
        send_item(rfla_pkg::OP_FREE_ALL, 5'd21, 0);
        for (int i = 0; i <= rfla_pkg::NUM_REGS; i++) begin
            send_item(rfla_pkg::OP_ALLOC, 5'(i), 0);
        end
        send_item(rfla_pkg::OP_FREE, 5'd17, 0);
        send_item(rfla_pkg::OP_FREE_ALL, 5'd10, 0);

        steady = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                steady = ($urandom_range(0, 2) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                op  = rfla_pkg::OP_ALLOC;
                rid = 5'($urandom_range(0, 31));
            end else if (roll < 67) begin
                op  = rfla_pkg::OP_FREE;
                rid = pick_reg();
            end else if (roll < 96) begin
                op  = rfla_pkg::OP_MARK;
                rid = pick_reg();
            end else begin
                op  = rfla_pkg::OP_FREE_ALL;
                rid = 5'($urandom_range(0, 31));
            end
            send_item(op, rid, pick_gap(steady));
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
